// ===== rtl/core/bfs_visit_order_engine_defines.svh =====
// ----------------------------------------------------------------------------
// bfs_visit_order_engine_defines.svh
// Assertion macros for the breadth-first visit-order engine. The enclosing
// module must have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BFS_VISIT_ORDER_ENGINE_DEFINES_SVH
`define BFS_VISIT_ORDER_ENGINE_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define BFSV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define BFSV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bfsv_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsv_pkg
// Shared types, codes and defaults of the breadth-first visit-order engine.
// ----------------------------------------------------------------------------
package bfsv_pkg;

	localparam int unsigned NODE_COUNT_DEF = 16;
	localparam int unsigned ADJ_SLOTS_DEF  = 64;
	localparam int unsigned CAP_BITS_DEF   = 16;

	localparam int unsigned VERT_W  = 4;
	localparam int unsigned CAP_W   = 16;
	localparam int unsigned ORDER_W = 4;
	localparam int unsigned VIN_CNT = 1 << VERT_W;

	typedef enum logic {
		REQ_ADD = 1'b0,
		REQ_RUN = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_ADDED = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_VISIT = 2'd2
	} status_t;

	typedef struct packed {
		req_kind_t           req_type;
		logic [VERT_W-1:0]   source_vertex;
		logic [VERT_W-1:0]   dest_vertex;
		logic [CAP_W-1:0]    capacity;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [ORDER_W-1:0]  order_index;
		logic [VERT_W-1:0]   vertex;
		logic [CAP_W-1:0]    capacity_seen;
		logic                last;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_req;
		logic add_fwd;
		logic add_rev;
		logic load_add;
		logic run_init;
		logic deq;
		logic walk_adv;
		logic flush;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_run;
		logic drop;
		logic fifo_empty;
		logic head_null;
		logic walk_hit;
		logic link_null;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/bfsv_if.sv =====
// ----------------------------------------------------------------------------
// bfsv_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface bfsv_req_if;
	import bfsv_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bfsv_res_if;
	import bfsv_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bfsv_ram.sv =====
// ----------------------------------------------------------------------------
// bfsv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsv_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/bfsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfsv_ctrl
// Sequencer for edge insertion and breadth-first walks.
// ----------------------------------------------------------------------------
module bfsv_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bfsv_pkg::sts_t sts,
	output bfsv_pkg::cmd_t cmd
);
	import bfsv_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_ADD_FWD  = 8'b0000_0010,
		ST_ADD_REV  = 8'b0000_0100,
		ST_ADD_DONE = 8'b0000_1000,
		ST_RUN_INIT = 8'b0001_0000,
		ST_DEQ      = 8'b0010_0000,
		ST_WALK     = 8'b0100_0000,
		ST_FLUSH    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_d = sts.req_run ? ST_RUN_INIT : ST_ADD_FWD;
				end
			end
			ST_ADD_FWD: begin
				if (sts.drop) begin
					state_d = ST_ADD_DONE;
				end else begin
					cmd.add_fwd = 1'b1;
					state_d = ST_ADD_REV;
				end
			end
			ST_ADD_REV: begin
				cmd.add_rev = 1'b1;
				state_d = ST_ADD_DONE;
			end
			ST_ADD_DONE: begin
				if (sts.out_free) begin
					cmd.load_add = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RUN_INIT: begin
				cmd.run_init = 1'b1;
				state_d = ST_DEQ;
			end
			ST_DEQ: begin
				if (sts.fifo_empty) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.deq = 1'b1;
					if (!sts.head_null) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				// hold on a new discovery while the output beat is still pending
				if (!(sts.walk_hit && !sts.out_free)) begin
					cmd.walk_adv = 1'b1;
					if (sts.link_null) begin
						state_d = ST_DEQ;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/core/bfsv_dp.sv =====
// ----------------------------------------------------------------------------
// bfsv_dp
// Datapath: adjacency RAM, list heads, visited marks, vertex FIFO, pending
// record and output register.
// ----------------------------------------------------------------------------
module bfsv_dp #(
	parameter int unsigned NODE_COUNT = bfsv_pkg::NODE_COUNT_DEF,
	parameter int unsigned ADJ_SLOTS  = bfsv_pkg::ADJ_SLOTS_DEF,
	parameter int unsigned CAP_BITS   = bfsv_pkg::CAP_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bfsv_pkg::req_t in_data,
	output logic           out_valid,
	output bfsv_pkg::res_t out_data,
	input  logic           out_ready,
	input  bfsv_pkg::cmd_t cmd,
	output bfsv_pkg::sts_t sts
);
	import bfsv_pkg::*;

	// Only VIN_CNT distinct vertex numbers can ever arrive.
	localparam int unsigned VCNT = (NODE_COUNT < VIN_CNT) ? NODE_COUNT : VIN_CNT;
	localparam int unsigned VW   = $clog2(VCNT);
	localparam int unsigned CW   = $clog2(VCNT + 1);
	localparam int unsigned AW   = $clog2(ADJ_SLOTS);
	localparam int unsigned LW   = $clog2(ADJ_SLOTS + 1);
	localparam int unsigned WW   = VW + CAP_BITS + LW;
	localparam logic [LW-1:0] LINK_NULL = LW'(ADJ_SLOTS);

	logic [VW-1:0] mod_tab [VIN_CNT];

	for (genvar g = 0; g < VIN_CNT; g++) begin : g_mod
		localparam int unsigned RED = g % NODE_COUNT;
		assign mod_tab[g] = VW'(RED);
	end

	logic [VW-1:0]       src_q;
	logic [VW-1:0]       dst_q;
	logic [CAP_BITS-1:0] cap_q;
	logic                drop_q;

	logic [LW-1:0] used_q;
	logic [LW-1:0] head_q [VCNT];
	logic          visited_q [VCNT];
	logic [VW-1:0] fifo_q [VCNT];
	logic [CW-1:0] fhead_q;
	logic [CW-1:0] ftail_q;
	res_t          pend_q;
	res_t          pend_last;
	res_t          out_q;
	logic          out_valid_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [WW-1:0]       ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [WW-1:0]       ram_rdata;
	logic [VW-1:0]       rd_vert;
	logic [CAP_BITS-1:0] rd_cap;
	logic [LW-1:0]       rd_link;
	logic [VW-1:0]       cur_vert;
	logic [LW-1:0]       head_cur;
	logic                hit;
	logic                out_free;

	assign {rd_vert, rd_cap, rd_link} = ram_rdata;

	assign cur_vert = fifo_q[fhead_q[VW-1:0]];
	assign head_cur = head_q[cur_vert];
	assign hit      = !visited_q[rd_vert];
	assign out_free = !out_valid_q || out_ready;

	// pending record marked as the closing beat of a run
	always_comb begin
		pend_last      = pend_q;
		pend_last.last = 1'b1;
	end

	assign ram_we    = cmd.add_fwd || cmd.add_rev;
	assign ram_waddr = used_q[AW-1:0];
	assign ram_wdata = cmd.add_fwd ? {dst_q, cap_q, head_q[src_q]}
	                               : {src_q, {CAP_BITS{1'b0}}, head_q[dst_q]};
	assign ram_re    = (cmd.deq && (head_cur != LINK_NULL)) ||
	                   (cmd.walk_adv && (rd_link != LINK_NULL));
	assign ram_raddr = cmd.deq ? head_cur[AW-1:0] : rd_link[AW-1:0];

	bfsv_ram #(
		.WIDTH (WW),
		.DEPTH (ADJ_SLOTS)
	) u_adj_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts            = '0;
		sts.req_run    = (in_data.req_type == REQ_RUN);
		sts.drop       = drop_q;
		sts.fifo_empty = (fhead_q == ftail_q);
		sts.head_null  = (head_cur == LINK_NULL);
		sts.walk_hit   = hit;
		sts.link_null  = (rd_link == LINK_NULL);
		sts.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			fhead_q     <= '0;
			ftail_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < VCNT; i++) begin
				head_q[i]    <= LINK_NULL;
				visited_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.add_fwd) begin
				head_q[src_q] <= used_q;
				used_q        <= used_q + LW'(1);
			end
			if (cmd.add_rev) begin
				head_q[dst_q] <= used_q;
				used_q        <= used_q + LW'(1);
			end
			if (cmd.run_init) begin
				for (int i = 0; i < VCNT; i++) begin
					visited_q[i] <= (VW'(i) == src_q);
				end
				fhead_q <= '0;
				ftail_q <= CW'(1);
			end
			if (cmd.deq) begin
				fhead_q <= fhead_q + CW'(1);
			end
			if (cmd.walk_adv && hit) begin
				visited_q[rd_vert] <= 1'b1;
				ftail_q            <= ftail_q + CW'(1);
			end
			if (cmd.load_add || cmd.flush || (cmd.walk_adv && hit)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			src_q  <= mod_tab[in_data.source_vertex];
			dst_q  <= mod_tab[in_data.dest_vertex];
			cap_q  <= CAP_BITS'(in_data.capacity);
			drop_q <= (32'(used_q) + 32'd2) > 32'(ADJ_SLOTS);
		end
		if (cmd.run_init) begin
			fifo_q[0]            <= src_q;
			pend_q.status        <= STAT_VISIT;
			pend_q.order_index   <= '0;
			pend_q.vertex        <= VERT_W'(src_q);
			pend_q.capacity_seen <= '0;
			pend_q.last          <= 1'b0;
		end
		if (cmd.walk_adv && hit) begin
			fifo_q[ftail_q[VW-1:0]] <= rd_vert;
			out_q                   <= pend_q;
			pend_q.order_index      <= ORDER_W'(ftail_q);
			pend_q.vertex           <= VERT_W'(rd_vert);
			pend_q.capacity_seen    <= CAP_W'(rd_cap);
		end
		if (cmd.flush) begin
			out_q <= pend_last;
		end
		if (cmd.load_add) begin
			out_q.status        <= drop_q ? STAT_FULL : STAT_ADDED;
			out_q.order_index   <= '0;
			out_q.vertex        <= '0;
			out_q.capacity_seen <= '0;
			out_q.last          <= 1'b1;
		end
	end
endmodule

// ===== rtl/core/bfs_visit_order_engine.sv =====
// ----------------------------------------------------------------------------
// bfs_visit_order_engine
// Adjacency-list store with a breadth-first walker that reports visit order.
// ----------------------------------------------------------------------------
// Requests arrive one beat at a time on req and are worked one at a time;
// req.ready is high only while the engine is idle. An add-edge beat puts a
// forward entry at the head of the source's list and a reverse entry (capacity
// 0) at the head of the destination's list, then returns one status beat.
// When fewer than two slots are free the edge is dropped with a full status.
// A run beat clears the visited marks and walks breadth-first from the start
// vertex, each list newest entry first, returning one visit beat per
// discovered vertex (start vertex first, order 0, capacity 0); the final beat
// carries last. The walk dequeues each reached vertex and then reads its
// adjacency entries one at a time through the single read port of the
// adjacency RAM. A stalled res channel holds the walk. Vertex numbers are
// reduced modulo NODE_COUNT; capacities are kept in their low CAP_BITS bits.
// There is no clearing pass after reset.
`include "bfs_visit_order_engine_defines.svh"

module bfs_visit_order_engine #(
	parameter int unsigned NODE_COUNT = bfsv_pkg::NODE_COUNT_DEF,
	parameter int unsigned ADJ_SLOTS  = bfsv_pkg::ADJ_SLOTS_DEF,
	parameter int unsigned CAP_BITS   = bfsv_pkg::CAP_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bfsv_req_if.sink   req,
	bfsv_res_if.source res
);
	import bfsv_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic flush_beat_ok;

	// Sequencer: owns the request handshake and issues at most one command per cycle.
	bfsv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: the adjacency RAM, list heads, visited marks and vertex FIFO.
	// A pending record register holds the newest discovery so that the final
	// beat can be marked last; the output register decouples the res side.
	bfsv_dp #(
		.NODE_COUNT (NODE_COUNT),
		.ADJ_SLOTS  (ADJ_SLOTS),
		.CAP_BITS   (CAP_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (req.data),
		.out_valid (res.valid),
		.out_data  (res.data),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Closing visit beat as presented on res.
	assign flush_beat_ok = res.valid && res.data.last && (res.data.status == STAT_VISIT);

	// Commands are exclusive: the sequencer drives one step at a time.
	`BFSV_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0(cmd), "more than one command issued")
	// While idle, any beat still waiting must be the closing one of a request.
	`BFSV_ASSERT_IMP(a_idle_last, req.ready && res.valid, res.data.last, "idle, beat not final")
	// Flushing the pending record always presents a final visit beat.
	`BFSV_ASSERT_NXT(a_flush_out, cmd.flush, flush_beat_ok, "flush gave no final visit beat")
endmodule
